FILE: rtl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_STR  = 4'b0010,
		MODE_ESC  = 4'b0100,
		MODE_HEX  = 4'b1000
	} mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	localparam logic [7:0]  CH_QUOTE = 8'h22;
	localparam logic [7:0]  CH_BSLASH = 8'h5C;
	localparam logic [7:0]  CH_SLASH = 8'h2F;
	localparam logic [7:0]  CH_B = 8'h62;
	localparam logic [7:0]  CH_F = 8'h66;
	localparam logic [7:0]  CH_N = 8'h6E;
	localparam logic [7:0]  CH_R = 8'h72;
	localparam logic [7:0]  CH_T = 8'h74;
	localparam logic [7:0]  CH_U = 8'h75;

	localparam logic [15:0] UTF8_LIM1 = 16'h0080;
	localparam logic [15:0] UTF8_LIM2 = 16'h0800;
	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_CONT = 8'h80;
	localparam logic [5:0]  UTF8_MASK = 6'h3F;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  hex_cnt;
		logic [15:0] cp;
	} dec_state_t;

	// Up to three result beats produced by one input beat, first beat in b0.
	typedef struct packed {
		logic [1:0] cnt;
		kind_t      kind;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} res_grp_t;

	// Returns {valid, value} for one ASCII hex digit.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/jsu_decode.sv
`default_nettype none

module jsu_decode import jsu_pkg::*; (
	input  wire dec_state_t st,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_data,
	output dec_state_t      nxt,
	output res_grp_t        grp
);

	logic [4:0]  hd;
	logic [15:0] cp_new;

	assign hd = hex_digit(data_byte);
	assign cp_new = {st.cp[11:0], hd[3:0]};

	always_comb begin
		nxt = st;
		grp = '{cnt: 2'd0, kind: KIND_BYTE, b0: 8'd0, b1: 8'd0, b2: 8'd0};
		if (end_of_data) begin
			if (st.mode != MODE_IDLE) begin
				grp.cnt  = 2'd1;
				grp.kind = KIND_ERR;
				nxt      = '{mode: MODE_IDLE, hex_cnt: 2'd0, cp: 16'd0};
			end
		end else begin
			unique case (st.mode)
				MODE_IDLE: begin
					if (data_byte == CH_QUOTE) begin
						nxt.mode = MODE_STR;
					end else begin
						grp.cnt  = 2'd1;
						grp.kind = KIND_ERR;
						nxt      = '{mode: MODE_IDLE, hex_cnt: 2'd0, cp: 16'd0};
					end
				end
				MODE_STR: begin
					if (data_byte == CH_QUOTE) begin
						grp.cnt  = 2'd1;
						grp.kind = KIND_END;
						nxt      = '{mode: MODE_IDLE, hex_cnt: 2'd0, cp: 16'd0};
					end else if (data_byte == CH_BSLASH) begin
						nxt.mode = MODE_ESC;
					end else begin
						grp.cnt = 2'd1;
						grp.b0  = data_byte;
					end
				end
				MODE_ESC: begin
					grp.cnt  = 2'd1;
					nxt.mode = MODE_STR;
					unique case (data_byte)
						CH_QUOTE:  grp.b0 = 8'h22;
						CH_BSLASH: grp.b0 = 8'h5C;
						CH_SLASH:  grp.b0 = 8'h2F;
						CH_B:      grp.b0 = 8'h08;
						CH_F:      grp.b0 = 8'h0C;
						CH_N:      grp.b0 = 8'h0A;
						CH_R:      grp.b0 = 8'h0D;
						CH_T:      grp.b0 = 8'h09;
						CH_U: begin
							grp.cnt = 2'd0;
							nxt     = '{mode: MODE_HEX, hex_cnt: 2'd0, cp: 16'd0};
						end
						default: begin
							grp.kind = KIND_ERR;
							nxt      = '{mode: MODE_IDLE, hex_cnt: 2'd0, cp: 16'd0};
						end
					endcase
				end
				MODE_HEX: begin
					if (!hd[4]) begin
						grp.cnt  = 2'd1;
						grp.kind = KIND_ERR;
						nxt      = '{mode: MODE_IDLE, hex_cnt: 2'd0, cp: 16'd0};
					end else if (st.hex_cnt == 2'd3) begin
						nxt = '{mode: MODE_STR, hex_cnt: 2'd0, cp: 16'd0};
						if (cp_new < UTF8_LIM1) begin
							grp.cnt = 2'd1;
							grp.b0  = cp_new[7:0];
						end else if (cp_new < UTF8_LIM2) begin
							grp.cnt = 2'd2;
							grp.b0  = UTF8_LEAD2 | {3'd0, cp_new[10:6]};
							grp.b1  = UTF8_CONT | {2'd0, cp_new[5:0] & UTF8_MASK};
						end else begin
							grp.cnt = 2'd3;
							grp.b0  = UTF8_LEAD3 | {4'd0, cp_new[15:12]};
							grp.b1  = UTF8_CONT | {2'd0, cp_new[11:6] & UTF8_MASK};
							grp.b2  = UTF8_CONT | {2'd0, cp_new[5:0] & UTF8_MASK};
						end
					end else begin
						nxt.hex_cnt = st.hex_cnt + 2'd1;
						nxt.cp      = cp_new;
					end
				end
				default: begin
					nxt = '{mode: MODE_IDLE, hex_cnt: 2'd0, cp: 16'd0};
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/json_string_unescape_core.sv
`default_nettype none

// Streaming decoder for one JSON string literal: raw JSON bytes enter one per beat on the
// slave side, starting with the opening quote, and decoded string bytes leave on the master
// side, followed by an end beat at the closing quote or an error beat on malformed input.
// The block takes one input beat per cycle unless the result register is stalled or busy;
// each byte is registered, decoded and written to the result register that drives the output.
// Quotes opening a string and backslashes give no output beat. The fourth hex digit of a \u
// escape gives up to three UTF-8 beats, leaving one per cycle while the master side is ready.
// Surrogate pairs are not combined; each \u value is encoded on its own.
module json_string_unescape_core import jsu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  wire logic       s_axis_tlast,  // end_of_data
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
	output logic [1:0]      m_axis_tuser,  // [1:0] kind
	output logic            m_axis_tlast   // last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eod_s1;

	dec_state_t st_q;
	dec_state_t st_nxt;
	res_grp_t   grp;

	logic [1:0] cnt_q;
	kind_t      kind_q;
	logic [7:0] b0_q;
	logic [7:0] b1_q;
	logic [7:0] b2_q;

	logic take;
	logic out_free;
	logic adv;
	logic load;

	jsu_decode u_decode (
		.st          (st_q),
		.data_byte   (byte_s1),
		.end_of_data (eod_s1),
		.nxt         (st_nxt),
		.grp         (grp)
	);

	assign take     = m_axis_tvalid && m_axis_tready;
	assign out_free = (cnt_q == 2'd0) || (take && cnt_q == 2'd1);
	assign adv      = valid_s1 && ((grp.cnt == 2'd0) || out_free);
	assign load     = adv && (grp.cnt != 2'd0);

	assign s_axis_tready = !valid_s1 || adv;

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = b0_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '{mode: MODE_IDLE, hex_cnt: 2'd0, cp: 16'd0};
			cnt_q    <= 2'd0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				st_q <= st_nxt;
			end
			if (load) begin
				cnt_q <= grp.cnt;
			end else if (take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eod_s1  <= s_axis_tlast;
		end
		if (load) begin
			kind_q <= grp.kind;
			b0_q   <= grp.b0;
			b1_q   <= grp.b1;
			b2_q   <= grp.b2;
		end else if (take) begin
			b0_q <= b1_q;
			b1_q <= b2_q;
		end
	end

	// A beat that closes or breaks a string is always alone in its group.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_BYTE |-> m_axis_tlast)
		else $error("end or error beat without last");

	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode == MODE_IDLE |-> st_q.hex_cnt == 2'd0 && st_q.cp == 16'd0)
		else $error("escape state left over while idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && m_axis_tvalid)
		else $error("input stalled without pending output");

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q > 2'd1 |-> kind_q == KIND_BYTE)
		else $error("multi-beat group of non-byte results");

endmodule

`default_nettype wire

FILE: tb/sv/json_string_unescape_core_tb.sv
`default_nettype none

module json_string_unescape_core_tb;
	import jsu_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	beat_t       pending_beats[$];
	int          err_cnt = 0;
	int          sent_cnt = 0;
	bit          tx_idle = 1'b0;
	bit          rx_idle = 1'b0;
	int          rx_stall_left = 0;

	mode_t       dec_mode = MODE_IDLE;
	logic [1:0]  dec_hex_cnt = 2'd0;
	logic [15:0] dec_cp = 16'd0;

	logic [7:0]  esc_letters[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

	json_string_unescape_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return {1'b1, 4'(c - "0")};
		end else if (c >= "a" && c <= "f") begin
			return {1'b1, 4'(c - "a" + 8'd10)};
		end else if (c >= "A" && c <= "F") begin
			return {1'b1, 4'(c - "A" + 8'd10)};
		end
		return 5'd0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10) begin
			return 8'("0") + 8'(v);
		end
		return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
	endfunction

	function automatic bit is_escape_letter(input logic [7:0] c);
		foreach (esc_letters[i]) begin
			if (esc_letters[i] == c) begin
				return 1'b1;
			end
		end
		return c == CH_U;
	endfunction

	function automatic beat_t mk_beat(input logic [7:0] d, input kind_t k);
		beat_t r;
		r.data = d;
		r.kind = k;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic return_to_idle();
		dec_mode = MODE_IDLE;
		dec_hex_cnt = 2'd0;
		dec_cp = 16'd0;
	endtask

	// Advances the decoder state by one raw byte and queues the beats it produces.
	task automatic decode_byte(input logic [7:0] c, input logic eod);
		beat_t r[$];
		logic [4:0] hv;
		logic [7:0] b;
		logic [15:0] cp;
		if (eod) begin
			if (dec_mode != MODE_IDLE) begin
				r.push_back(mk_beat(8'h00, KIND_ERR));
				return_to_idle();
			end
		end else begin
			case (dec_mode)
				MODE_IDLE: begin
					if (c == CH_QUOTE) begin
						dec_mode = MODE_STR;
					end else begin
						r.push_back(mk_beat(8'h00, KIND_ERR));
						return_to_idle();
					end
				end
				MODE_STR: begin
					if (c == CH_QUOTE) begin
						r.push_back(mk_beat(8'h00, KIND_END));
						return_to_idle();
					end else if (c == CH_BSLASH) begin
						dec_mode = MODE_ESC;
					end else begin
						r.push_back(mk_beat(c, KIND_BYTE));
					end
				end
				MODE_ESC: begin
					case (c)
						CH_QUOTE: b = CH_QUOTE;
						CH_BSLASH: b = CH_BSLASH;
						CH_SLASH: b = CH_SLASH;
						CH_B: b = 8'h08;
						CH_F: b = 8'h0C;
						CH_N: b = 8'h0A;
						CH_R: b = 8'h0D;
						CH_T: b = 8'h09;
						default: b = 8'h00;
					endcase
					if (c == CH_U) begin
						dec_mode = MODE_HEX;
						dec_hex_cnt = 2'd0;
						dec_cp = 16'd0;
					end else if (is_escape_letter(c)) begin
						r.push_back(mk_beat(b, KIND_BYTE));
						dec_mode = MODE_STR;
					end else begin
						r.push_back(mk_beat(8'h00, KIND_ERR));
						return_to_idle();
					end
				end
				default: begin
					hv = nibble_of(c);
					if (!hv[4]) begin
						r.push_back(mk_beat(8'h00, KIND_ERR));
						return_to_idle();
					end else begin
						cp = {dec_cp[11:0], hv[3:0]};
						if (dec_hex_cnt == 2'd3) begin
							if (cp < 16'h0080) begin
								r.push_back(mk_beat(cp[7:0], KIND_BYTE));
							end else if (cp < 16'h0800) begin
								r.push_back(mk_beat(8'hC0 | 8'(cp[10:6]), KIND_BYTE));
								r.push_back(mk_beat(8'h80 | 8'(cp[5:0]), KIND_BYTE));
							end else begin
								r.push_back(mk_beat(8'hE0 | 8'(cp[15:12]), KIND_BYTE));
								r.push_back(mk_beat(8'h80 | 8'(cp[11:6]), KIND_BYTE));
								r.push_back(mk_beat(8'h80 | 8'(cp[5:0]), KIND_BYTE));
							end
							dec_mode = MODE_STR;
							dec_hex_cnt = 2'd0;
							dec_cp = 16'd0;
						end else begin
							dec_cp = cp;
							dec_hex_cnt = dec_hex_cnt + 2'd1;
						end
					end
				end
			endcase
		end
		if (r.size() > 0) begin
			r[r.size() - 1].last = 1'b1;
		end
		foreach (r[i]) begin
			pending_beats.push_back(r[i]);
		end
	endtask

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic send_beat(input logic [7:0] c, input logic eod);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= eod;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		decode_byte(c, eod);
		sent_cnt++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_beat(s[i], 1'b0);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_beats.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (rx_stall_left != 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left <= rx_stall_left - 1;
		end else if (rx_idle && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left <= $urandom_range(0, 3);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat data=%h kind=%0d last=%b", $time,
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				err_cnt++;
			end else begin
				want = pending_beats.pop_front();
				if (m_axis_tdata !== want.data || m_axis_tuser !== want.kind ||
						m_axis_tlast !== want.last) begin
					$display("%0t: mismatch expected data=%h kind=%0d last=%b, actual data=%h kind=%0d last=%b",
						$time, want.data, want.kind, want.last,
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					err_cnt++;
				end
			end
		end
	end

	task automatic test_idle_errors();
		send_beat(8'hFF, 1'b1);
		send_beat(8'hFF, 1'b0);
	endtask

	task automatic test_raw_bytes_and_bad_escape();
		send_beat(CH_QUOTE, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(CH_BSLASH, 1'b0);
		send_beat("q", 1'b0);
	endtask

	task automatic test_unicode_escapes();
		send_text("\"\\u07fF\\uFfa9\\n\"");
		send_text("\"\\u0g");
	endtask

	task automatic test_eod_in_string();
		send_beat(CH_QUOTE, 1'b0);
		send_beat(8'h00, 1'b1);
	endtask

	task automatic send_string();
		logic [7:0] b;
		logic [15:0] cp;
		int nseg;
		int sz;
		if ($urandom_range(0, 9) == 0) begin
			b = 8'($urandom);
			while (b == CH_QUOTE) b = 8'($urandom);
			send_beat(b, 1'($urandom_range(0, 1)));
		end
		send_beat(CH_QUOTE, 1'b0);
		nseg = $urandom_range(0, 6);
		for (int k = 0; k < nseg; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					b = 8'($urandom);
					while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom);
					send_beat(b, 1'b0);
				end
				4, 5: begin
					send_beat(CH_BSLASH, 1'b0);
					send_beat(esc_letters[3'($urandom_range(0, 7))], 1'b0);
				end
				6, 7, 8: begin
					sz = $urandom_range(0, 2);
					cp = (sz == 0) ? 16'($urandom_range(0, 16'h007F)) :
						(sz == 1) ? 16'($urandom_range(16'h0080, 16'h07FF)) :
						16'($urandom_range(16'h0800, 16'hFFFF));
					send_beat(CH_BSLASH, 1'b0);
					send_beat(CH_U, 1'b0);
					for (int d = 3; d >= 0; d--) begin
						send_beat(hex_char(cp[d * 4 +: 4], 1'($urandom_range(0, 1))), 1'b0);
					end
				end
				default: begin
					sz = $urandom_range(0, 2);
					b = 8'($urandom);
					if (sz == 0) begin
						while (is_escape_letter(b)) b = 8'($urandom);
						send_beat(CH_BSLASH, 1'b0);
						send_beat(b, 1'b0);
					end else if (sz == 1) begin
						while (nibble_of(b) != 5'd0) b = 8'($urandom);
						send_beat(CH_BSLASH, 1'b0);
						send_beat(CH_U, 1'b0);
						repeat ($urandom_range(0, 3)) begin
							send_beat(hex_char(4'($urandom), 1'($urandom_range(0, 1))), 1'b0);
						end
						send_beat(b, 1'b0);
					end else begin
						send_beat(b, 1'b1);
					end
					return;
				end
			endcase
		end
		send_beat(CH_QUOTE, 1'b0);
	endtask

	task automatic test_random_strings(input int target);
		while (sent_cnt < target) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			send_string();
		end
	endtask

	task automatic test_no_idling(input int target);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		while (sent_cnt < target) begin
			send_string();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		test_idle_errors();
		test_raw_bytes_and_bad_escape();
		test_unicode_escapes();
		test_eod_in_string();
		wait_drained();
		test_random_strings(sent_cnt + 360);
		wait_drained();
		test_no_idling(sent_cnt + 80);
		wait_drained();
		if (err_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
